@@ rtl/core/lpba_pkg.sv @@
// Shared types, constants and defaults for the lepton pair binned accumulator.
`default_nettype none

package lpba_pkg;

    // Field widths fixed by the item formats.
    localparam int ETA_W     = 9;
    localparam int PT_W      = 12;
    localparam int MASS_W    = 16;
    localparam int WEIGHT_W  = 32;
    localparam int ACC_W     = 40;
    localparam int ENTRY_W   = 9;
    localparam int ADDR_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Packed edge registers.
    localparam int ETA_EDGE_COUNT = 5;
    localparam int PT_EDGE_COUNT  = 5;
    localparam int ETA_EDGES_W    = ETA_W * ETA_EDGE_COUNT;
    localparam int PT_EDGES_W     = PT_W * PT_EDGE_COUNT;

    // Bin numbers and the linear table index, sized for the largest binning.
    localparam int BIN_W = 3;
    localparam int LIN_W = 10;

    localparam int TABLE_DEPTH = 256;

    // Default configuration.
    localparam int ETA_BINS_DEFAULT    = 4;
    localparam int PT_BINS_DEFAULT     = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Only the five packed eta edges are kept; the upper bits of the register
    // are never looked at.
    localparam logic [ETA_EDGES_W-1:0] ETA_EDGES_RESET =
        ETA_EDGES_W'(55'd11685720961436800);
    localparam logic [PT_EDGES_W-1:0]  PT_EDGES_RESET  = 60'd731305891926343700;
    localparam logic [MASS_W-1:0]      MASS_LOW_RESET  = 16'd1136;
    localparam logic [MASS_W-1:0]      MASS_HIGH_RESET = 16'd1776;
    localparam logic [MASS_W-1:0]      PEAK_LOW_RESET  = 16'd1296;
    localparam logic [MASS_W-1:0]      PEAK_HIGH_RESET = 16'd1616;

    // Weight of 1.0 in Q16.16.
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 32'sh0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ETA_EDGES    = 3'd0,
        CFG_PT_EDGES     = 3'd1,
        CFG_MASS_LOW     = 3'd2,
        CFG_MASS_HIGH    = 3'd3,
        CFG_PEAK_LOW     = 3'd4,
        CFG_PEAK_HIGH    = 3'd5,
        CFG_SUBTRACT_BKG = 3'd6,
        CFG_IS_DATA      = 3'd7
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FILLED     = 3'd0,
        ST_NOT_TIGHT  = 3'd1,
        ST_MASS_OUT   = 3'd2,
        ST_NO_BIN     = 3'd3,
        ST_NO_CHARGE  = 3'd4,
        ST_READ       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    // One classified request on its way from the front to the back.
    typedef struct packed {
        status_t                     status;
        logic [ENTRY_W-1:0]          entry_index;
        logic signed [WEIGHT_W-1:0]  weight;
    } lpba_op_t;

endpackage

`default_nettype wire

@@ rtl/core/lpba_evt_if.sv @@
// Event request channel: valid/ready handshake with the event fields.
`default_nettype none

interface lpba_evt_if
    import lpba_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [ETA_W-1:0]           eta_a;
    logic [ETA_W-1:0]           eta_b;
    logic [PT_W-1:0]            pt_a;
    logic [PT_W-1:0]            pt_b;
    logic [MASS_W-1:0]          mass;
    logic                       same_sign;
    logic                       opposite_sign;
    logic                       tight_a;
    logic                       tight_b;
    logic signed [WEIGHT_W-1:0] weight;
    logic [ENTRY_W-1:0]         read_entry;

    modport source (
        output valid, action, eta_a, eta_b, pt_a, pt_b, mass, same_sign,
               opposite_sign, tight_a, tight_b, weight, read_entry,
        input  ready
    );

    modport sink (
        input  valid, action, eta_a, eta_b, pt_a, pt_b, mass, same_sign,
               opposite_sign, tight_a, tight_b, weight, read_entry,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lpba_res_if.sv @@
// Result channel: valid/ready handshake with status, entry index and value.
`default_nettype none

interface lpba_res_if
    import lpba_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [ACC_W-1:0]  value;

    modport source (
        output valid, status, entry_index, value,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, value,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lpba_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
`default_nettype none

interface lpba_cfg_if
    import lpba_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lepton_pair_binned_accumulator.sv @@
// Top level of the lepton pair binned accumulator.
`default_nettype none

// The block takes one request per cycle on evt while its request queue has
// room, and answers every request with exactly one result on res, in order.
// An accumulate request checks the tight flags, the mass window and the
// charge flags, bins both leptons by edge compare, orders the pair by eta
// bin, shapes the weight and adds it, saturating to 40 bits, to one entry of
// the same-sign or opposite-sign table; a read request returns one entry.
// The front classifies a request in the cycle it is accepted and puts it in
// a short queue (QUEUE_DEPTH entries); the back then reads the table memory
// into a register in its IDLE state, and in its EXEC state, once the result
// register is free, updates the entry and loads the result register; it
// takes no new request from the queue until it is through with the last
// one. A result waiting in the output register does not stop the queue from
// filling. Both tables read as zero after reset: the back first writes zero
// into one entry of each table per cycle until all are cleared, and takes
// nothing from the queue, so up to QUEUE_DEPTH requests may be accepted
// meanwhile and wait there.
// Configuration writes on cfg are always taken at once and must only be
// issued while no request is in flight.
module lepton_pair_binned_accumulator
    import lpba_pkg::*;
#(
    parameter int ETA_BINS    = ETA_BINS_DEFAULT,
    parameter int PT_BINS     = PT_BINS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpba_evt_if.sink    evt,
    lpba_res_if.source  res,
    lpba_cfg_if.sink    cfg
);

    // Classified request entering the queue.
    lpba_op_t push_op;
    logic     push_valid;
    logic     push_ready;

    // Request leaving the queue for the table update.
    lpba_op_t pop_op;
    logic     pop_valid;
    logic     pop_ready;

    // Front: configuration registers, checks, bins, table index and weight.
    lpba_front #(
        .ETA_BINS (ETA_BINS),
        .PT_BINS  (PT_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .cfg        (cfg),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // The queue lets the front keep accepting while the back is busy.
    lpba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back: table memories, saturating update and the result register.
    lpba_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_op    (pop_op),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .res     (res)
    );

endmodule

`default_nettype wire

@@ rtl/core/lpba_front.sv @@
// Front end: configuration registers, event checks, binning and weight shaping.
`default_nettype none

module lpba_front
    import lpba_pkg::*;
#(
    parameter int ETA_BINS = ETA_BINS_DEFAULT,
    parameter int PT_BINS  = PT_BINS_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpba_evt_if.sink    evt,
    lpba_cfg_if.sink    cfg,
    output lpba_op_t    push_op,
    output logic        push_valid,
    input  wire logic   push_ready
);

    logic [ETA_EDGES_W-1:0] eta_edges_reg;
    logic [PT_EDGES_W-1:0]  pt_edges_reg;
    logic [MASS_W-1:0]      mass_low_reg;
    logic [MASS_W-1:0]      mass_high_reg;
    logic [MASS_W-1:0]      peak_low_reg;
    logic [MASS_W-1:0]      peak_high_reg;
    logic                   subtract_reg;
    logic                   is_data_reg;

    logic [ETA_W-1:0] eta_edge [ETA_BINS+1];
    logic [PT_W-1:0]  pt_edge  [PT_BINS+1];

    logic             e1_hit, e2_hit, p1_hit, p2_hit;
    logic [BIN_W-1:0] e1, e2, p1, p2;
    logic [BIN_W-1:0] low_e, up_e, low_p, up_p;
    logic [LIN_W-1:0] lin_index;
    logic             in_window, on_peak;

    logic signed [WEIGHT_W-1:0] base_w;
    logic signed [WEIGHT_W:0]   neg_w;
    logic signed [WEIGHT_W:0]   half_w;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_edges_reg <= ETA_EDGES_RESET;
            pt_edges_reg  <= PT_EDGES_RESET;
            mass_low_reg  <= MASS_LOW_RESET;
            mass_high_reg <= MASS_HIGH_RESET;
            peak_low_reg  <= PEAK_LOW_RESET;
            peak_high_reg <= PEAK_HIGH_RESET;
            subtract_reg  <= 1'b0;
            is_data_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_ETA_EDGES:    eta_edges_reg <= cfg.data[ETA_EDGES_W-1:0];
                CFG_PT_EDGES:     pt_edges_reg  <= cfg.data[PT_EDGES_W-1:0];
                CFG_MASS_LOW:     mass_low_reg  <= cfg.data[MASS_W-1:0];
                CFG_MASS_HIGH:    mass_high_reg <= cfg.data[MASS_W-1:0];
                CFG_PEAK_LOW:     peak_low_reg  <= cfg.data[MASS_W-1:0];
                CFG_PEAK_HIGH:    peak_high_reg <= cfg.data[MASS_W-1:0];
                CFG_SUBTRACT_BKG: subtract_reg  <= cfg.data[0];
                CFG_IS_DATA:      is_data_reg   <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // Unpack the edges; eta edges beyond the fifth read as the largest value.
    for (genvar g = 0; g <= ETA_BINS; g++)
    begin : g_eta_edge
        if (g < ETA_EDGE_COUNT)
        begin : g_stored
            assign eta_edge[g] = eta_edges_reg[ETA_W*g +: ETA_W];
        end
        else
        begin : g_missing
            assign eta_edge[g] = '1;
        end
    end

    for (genvar g = 0; g <= PT_BINS; g++)
    begin : g_pt_edge
        assign pt_edge[g] = pt_edges_reg[PT_W*g +: PT_W];
    end

    // Parallel edge compares; the highest matching bin wins.
    always_comb
    begin
        e1_hit = 1'b0;
        e2_hit = 1'b0;
        p1_hit = 1'b0;
        p2_hit = 1'b0;
        e1 = '0;
        e2 = '0;
        p1 = '0;
        p2 = '0;
        for (int i = 0; i < ETA_BINS; i++)
        begin
            if (evt.eta_a > eta_edge[i] && evt.eta_a <= eta_edge[i+1])
            begin
                e1_hit = 1'b1;
                e1 = BIN_W'(i);
            end
            if (evt.eta_b > eta_edge[i] && evt.eta_b <= eta_edge[i+1])
            begin
                e2_hit = 1'b1;
                e2 = BIN_W'(i);
            end
        end
        for (int j = 0; j < PT_BINS; j++)
        begin
            if (evt.pt_a > pt_edge[j] && evt.pt_a <= pt_edge[j+1])
            begin
                p1_hit = 1'b1;
                p1 = BIN_W'(j);
            end
            if (evt.pt_b > pt_edge[j] && evt.pt_b <= pt_edge[j+1])
            begin
                p2_hit = 1'b1;
                p2 = BIN_W'(j);
            end
        end
        // A pt above the last edge lands in the top bin.
        if (!p1_hit && evt.pt_a > pt_edge[PT_BINS])
        begin
            p1_hit = 1'b1;
            p1 = BIN_W'(PT_BINS - 1);
        end
        if (!p2_hit && evt.pt_b > pt_edge[PT_BINS])
        begin
            p2_hit = 1'b1;
            p2 = BIN_W'(PT_BINS - 1);
        end
    end

    // Lower eta bin first.
    always_comb
    begin
        if (e1 > e2)
        begin
            low_e = e2;
            up_e  = e1;
            low_p = p2;
            up_p  = p1;
        end
        else
        begin
            low_e = e1;
            up_e  = e2;
            low_p = p1;
            up_p  = p2;
        end
    end

    assign lin_index = ((LIN_W'(low_e) * LIN_W'(ETA_BINS) + LIN_W'(up_e))
                        * LIN_W'(PT_BINS) + LIN_W'(low_p))
                        * LIN_W'(PT_BINS) + LIN_W'(up_p);

    assign in_window = !(evt.mass < mass_low_reg || evt.mass > mass_high_reg);
    assign on_peak   = (evt.mass > peak_low_reg) && (evt.mass < peak_high_reg);

    // With background subtraction on, off-peak weights become floor(-w/2).
    assign base_w = is_data_reg ? WEIGHT_ONE : evt.weight;
    assign neg_w  = -{base_w[WEIGHT_W-1], base_w};
    assign half_w = neg_w >>> 1;

    always_comb
    begin
        push_op.status      = ST_FILLED;
        push_op.entry_index = '0;
        push_op.weight      = base_w;
        priority if (evt.action)
        begin
            push_op.status      = ST_READ;
            push_op.entry_index = evt.read_entry;
        end
        else if (!evt.tight_a || !evt.tight_b)
        begin
            push_op.status = ST_NOT_TIGHT;
        end
        else if (!in_window)
        begin
            push_op.status = ST_MASS_OUT;
        end
        else if (!evt.same_sign && !evt.opposite_sign)
        begin
            push_op.status = ST_NO_CHARGE;
        end
        else if (!e1_hit || !e2_hit || !p1_hit || !p2_hit
                 || lin_index >= LIN_W'(TABLE_DEPTH))
        begin
            push_op.status = ST_NO_BIN;
        end
        else
        begin
            push_op.status      = ST_FILLED;
            push_op.entry_index = {!evt.same_sign, lin_index[ADDR_W-1:0]};
            if (subtract_reg && !on_peak)
            begin
                push_op.weight = half_w[WEIGHT_W-1:0];
            end
        end
    end

    assign push_valid = evt.valid;
    assign evt.ready  = push_ready;

endmodule

`default_nettype wire

@@ rtl/core/lpba_queue.sv @@
// Small first-in first-out queue of classified requests between front and back.
`default_nettype none

module lpba_queue
    import lpba_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire lpba_op_t   push_op,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output lpba_op_t        pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpba_op_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lpba_back.sv @@
// Back end: table memories with read-modify-write update and the result register.
`default_nettype none

module lpba_back
    import lpba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lpba_op_t   q_op,
    input  wire logic       q_valid,
    output logic            q_ready,
    lpba_res_if.source      res
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [ACC_W-1:0] ss_mem [TABLE_DEPTH];
    logic [ACC_W-1:0] os_mem [TABLE_DEPTH];

    back_state_t state_reg, state_next;

    logic [ADDR_W-1:0] clear_addr_reg;
    logic              clear_last;
    logic              clearing;

    lpba_op_t          op_reg;
    logic [ACC_W-1:0]  ss_rd_reg;
    logic [ACC_W-1:0]  os_rd_reg;

    logic                     res_valid_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic [ENTRY_W-1:0]       res_index_reg;
    logic signed [ACC_W-1:0]  res_value_reg;

    logic [ADDR_W-1:0]        q_addr, op_addr;
    logic                     op_sel;
    logic                     out_free, exec_done, do_fill;
    logic signed [ACC_W-1:0]  cur_val;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;

    assign q_addr     = q_op.entry_index[ADDR_W-1:0];
    assign op_addr    = op_reg.entry_index[ADDR_W-1:0];
    assign op_sel     = op_reg.entry_index[ADDR_W];
    assign clear_last = (clear_addr_reg == '1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clear_last) state_next = BK_IDLE;
            BK_IDLE:  if (q_valid) state_next = BK_EXEC;
            BK_EXEC:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_ready   = 1'b0;
        exec_done = 1'b0;
        clearing  = 1'b0;
        unique case (state_reg)
            BK_CLEAR: clearing = 1'b1;
            BK_IDLE:  q_ready = 1'b1;
            BK_EXEC:  exec_done = out_free;
            default:  ;
        endcase
    end

    assign out_free = !res_valid_reg || res.ready;
    assign do_fill  = exec_done && (op_reg.status == ST_FILLED);

    assign cur_val  = op_sel ? os_rd_reg : ss_rd_reg;
    assign sum_wide = {cur_val[ACC_W-1], cur_val}
                      + {{(ACC_W + 1 - WEIGHT_W){op_reg.weight[WEIGHT_W-1]}}, op_reg.weight};

    always_comb
    begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clear_addr_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (exec_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // After reset one entry of each table is zeroed per cycle.
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            op_reg    <= q_op;
            ss_rd_reg <= ss_mem[q_addr];
            os_rd_reg <= os_mem[q_addr];
        end
        if (clearing)
        begin
            ss_mem[clear_addr_reg] <= '0;
            os_mem[clear_addr_reg] <= '0;
        end
        else if (do_fill)
        begin
            if (op_sel)
            begin
                os_mem[op_addr] <= sum_sat;
            end
            else
            begin
                ss_mem[op_addr] <= sum_sat;
            end
        end
        if (exec_done)
        begin
            res_status_reg <= op_reg.status;
            res_index_reg  <= op_reg.entry_index;
            res_value_reg  <= (op_reg.status == ST_READ) ? cur_val : '0;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.status      = res_status_reg;
    assign res.entry_index = res_index_reg;
    assign res.value       = res_value_reg;

    // A new result only appears right after an update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == BK_EXEC))
        else $error("result raised without an update cycle");

    // Only reads return a table value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg != ST_READ) |-> (res_value_reg == '0))
        else $error("non-read result carries a value");

    // Nothing is taken and nothing is answered while the tables are cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CLEAR) |-> (!q_ready && !res_valid_reg))
        else $error("request handled during the clearing pass");

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |=> (res_valid_reg && $stable(res_status_reg)
            && $stable(res_index_reg) && $stable(res_value_reg)))
        else $error("waiting result changed");

endmodule

`default_nettype wire

@@ bench/lepton_pair_binned_accumulator_tb.sv @@
// Self-checking testbench for the lepton pair binned accumulator.
`timescale 1ns / 100ps

module lepton_pair_binned_accumulator_tb
    import lpba_pkg::*;
;

    // Binning used by the instance; the block is built with the defaults.
    localparam int N_ETA = ETA_BINS_DEFAULT;
    localparam int N_PT  = PT_BINS_DEFAULT;

    // Table sums are clamped to the signed 40-bit range.
    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -64'sd549755813888;

    // Cycles without any accepted request, result or register write before
    // the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    // One event or read request as it is driven onto the event channel.
    typedef struct {
        bit                         action;
        bit [ETA_W-1:0]             eta_a;
        bit [ETA_W-1:0]             eta_b;
        bit [PT_W-1:0]              pt_a;
        bit [PT_W-1:0]              pt_b;
        bit [MASS_W-1:0]            mass;
        bit                         same_sign;
        bit                         opposite_sign;
        bit                         tight_a;
        bit                         tight_b;
        bit signed [WEIGHT_W-1:0]   weight;
        bit [ENTRY_W-1:0]           read_entry;
    } pair_req_t;

    // The result that one request must produce.
    typedef struct {
        status_t                    status;
        bit [ENTRY_W-1:0]           entry_index;
        bit signed [ACC_W-1:0]      value;
    } pair_res_t;

    logic clk = 1'b0;
    logic rst_n;

    lpba_evt_if evt();
    lpba_res_if res();
    lpba_cfg_if cfg();

    lepton_pair_binned_accumulator #(
        .ETA_BINS (N_ETA),
        .PT_BINS  (N_PT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    // Our own copy of the configuration registers. The edge registers are
    // kept at full write width; only the packed edge fields are ever looked at.
    bit [63:0]         eta_edges_q;
    bit [63:0]         pt_edges_q;
    bit [MASS_W-1:0]   mass_low_q;
    bit [MASS_W-1:0]   mass_high_q;
    bit [MASS_W-1:0]   peak_low_q;
    bit [MASS_W-1:0]   peak_high_q;
    bit                subtract_q;
    bit                is_data_q;

    // Our own copy of both weight tables, as plain 64-bit sums.
    longint same_sign_sums[TABLE_DEPTH];
    longint opposite_sign_sums[TABLE_DEPTH];

    // Results owed by the block, oldest first.
    pair_res_t pending_results[$];
    pair_res_t oldest_result;

    bit [ENTRY_W-1:0] last_filled;
    bit               idle_enable;
    int               error_count;
    int               stalled_cycles;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Edges past the last packed field read as the top of the field range.
    function automatic int eta_edge_at(int i);
        if (i >= ETA_EDGE_COUNT)
            return 2**ETA_W - 1;
        return int'(eta_edges_q[ETA_W*i +: ETA_W]);
    endfunction

    function automatic int pt_edge_at(int i);
        if (i >= PT_EDGE_COUNT)
            return 2**PT_W - 1;
        return int'(pt_edges_q[PT_W*i +: PT_W]);
    endfunction

    // A bin matches when its lower edge is below the value and its upper edge
    // is at or above it. The edges need not ascend, so several bins may match
    // and the highest one wins; -1 means no bin.
    function automatic int eta_bin_of(int v);
        int b = -1;
        for (int i = 0; i < N_ETA; i++)
            if (v > eta_edge_at(i) && v <= eta_edge_at(i + 1))
                b = i;
        return b;
    endfunction

    // Pt above the last edge lands in the top bin.
    function automatic int pt_bin_of(int v);
        int b = -1;
        for (int j = 0; j < N_PT; j++)
            if (v > pt_edge_at(j) && v <= pt_edge_at(j + 1))
                b = j;
        if (b < 0 && v > pt_edge_at(N_PT))
            b = N_PT - 1;
        return b;
    endfunction

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_MAX)
            return SUM_MAX;
        if (s < SUM_MIN)
            return SUM_MIN;
        return s;
    endfunction

    // Works out the result of one accepted request and applies its table
    // update, so requests must be passed in the order the block takes them.
    function automatic pair_res_t accumulate_pair(pair_req_t r);
        pair_res_t o;
        int        e1, e2, p1, p2, lo_e, up_e, lo_p, up_p, idx;
        longint    w;
        o.status      = ST_FILLED;
        o.entry_index = '0;
        o.value       = '0;
        if (r.action) begin
            o.status      = ST_READ;
            o.entry_index = r.read_entry;
            o.value = ACC_W'(r.read_entry[ADDR_W] ? opposite_sign_sums[r.read_entry[ADDR_W-1:0]]
                                                  : same_sign_sums[r.read_entry[ADDR_W-1:0]]);
            return o;
        end
        if (!(r.tight_a && r.tight_b)) begin
            o.status = ST_NOT_TIGHT;
            return o;
        end
        if (r.mass < mass_low_q || r.mass > mass_high_q) begin
            o.status = ST_MASS_OUT;
            return o;
        end
        if (!r.same_sign && !r.opposite_sign) begin
            o.status = ST_NO_CHARGE;
            return o;
        end
        e1 = eta_bin_of(r.eta_a);
        e2 = eta_bin_of(r.eta_b);
        p1 = pt_bin_of(r.pt_a);
        p2 = pt_bin_of(r.pt_b);
        if (e1 < 0 || e2 < 0 || p1 < 0 || p2 < 0) begin
            o.status = ST_NO_BIN;
            return o;
        end
        // The lepton with the lower eta bin goes first, carrying its pt bin.
        if (e1 > e2) begin
            lo_e = e2; up_e = e1; lo_p = p2; up_p = p1;
        end
        else begin
            lo_e = e1; up_e = e2; lo_p = p1; up_p = p2;
        end
        idx = ((lo_e * N_ETA + up_e) * N_PT + lo_p) * N_PT + up_p;
        if (idx >= TABLE_DEPTH) begin
            o.status = ST_NO_BIN;
            return o;
        end
        w = is_data_q ? longint'(WEIGHT_ONE) : longint'(r.weight);
        // Off the peak the weight becomes minus one half of itself, rounded
        // toward minus infinity, which is what an arithmetic shift gives.
        if (subtract_q && !(r.mass > peak_low_q && r.mass < peak_high_q))
            w = (-w) >>> 1;
        if (r.same_sign) begin
            same_sign_sums[idx] = clamp_sum(same_sign_sums[idx], w);
            o.entry_index = ENTRY_W'(idx);
        end
        else begin
            opposite_sign_sums[idx] = clamp_sum(opposite_sign_sums[idx], w);
            o.entry_index = ENTRY_W'(idx) | ENTRY_W'(TABLE_DEPTH);
        end
        last_filled = o.entry_index;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    // Every field but the action random; most of these get rejected early.
    function automatic pair_req_t noise_pair();
        pair_req_t r;
        r.action        = 1'b0;
        r.eta_a         = ETA_W'($urandom);
        r.eta_b         = ETA_W'($urandom);
        r.pt_a          = PT_W'($urandom);
        r.pt_b          = PT_W'($urandom);
        r.mass          = MASS_W'($urandom);
        r.same_sign     = 1'($urandom);
        r.opposite_sign = 1'($urandom);
        r.tight_a       = 1'($urandom);
        r.tight_b       = 1'($urandom);
        r.weight        = WEIGHT_W'($urandom);
        r.read_entry    = ENTRY_W'($urandom);
        return r;
    endfunction

    // Values on or just above an edge are favored, since that is where the
    // compares turn over.
    function automatic bit [ETA_W-1:0] pick_binned_eta();
        bit [ETA_W-1:0] v;
        for (int k = 0; k < 16; k++) begin
            case ($urandom_range(3))
                0:       v = ETA_W'(eta_edge_at($urandom_range(ETA_EDGE_COUNT - 1)));
                1:       v = ETA_W'(eta_edge_at($urandom_range(ETA_EDGE_COUNT - 1)) + 1);
                default: v = ETA_W'($urandom);
            endcase
            if (eta_bin_of(v) >= 0)
                return v;
        end
        return v;
    endfunction

    function automatic bit [PT_W-1:0] pick_binned_pt();
        bit [PT_W-1:0] v;
        for (int k = 0; k < 16; k++) begin
            case ($urandom_range(3))
                0:       v = PT_W'(pt_edge_at($urandom_range(PT_EDGE_COUNT - 1)));
                1:       v = PT_W'(pt_edge_at($urandom_range(PT_EDGE_COUNT - 1)) + 1);
                default: v = PT_W'($urandom);
            endcase
            if (pt_bin_of(v) >= 0)
                return v;
        end
        return v;
    endfunction

    // Mass inside the window (random if it is inverted), now and then at or next to a peak bound.
    function automatic bit [MASS_W-1:0] pick_window_mass();
        if (mass_low_q > mass_high_q)
            return MASS_W'($urandom);
        if ($urandom_range(3) == 0)
            case ($urandom_range(3))
                0:       return peak_low_q;
                1:       return peak_low_q + 1'b1;
                2:       return peak_high_q - 1'b1;
                default: return peak_high_q;
            endcase
        return MASS_W'($urandom_range(mass_high_q, mass_low_q));
    endfunction

    // A pair that passes every check under the current settings, where the
    // settings allow one.
    function automatic pair_req_t well_formed_pair();
        pair_req_t r;
        r         = noise_pair();
        r.tight_a = 1'b1;
        r.tight_b = 1'b1;
        r.mass    = pick_window_mass();
        case ($urandom_range(3))
            0:       {r.same_sign, r.opposite_sign} = 2'b10;
            1:       {r.same_sign, r.opposite_sign} = 2'b11;
            default: {r.same_sign, r.opposite_sign} = 2'b01;
        endcase
        r.eta_a = pick_binned_eta();
        r.eta_b = pick_binned_eta();
        r.pt_a  = pick_binned_pt();
        r.pt_b  = pick_binned_pt();
        if ($urandom_range(3) == 0)
            r.weight = WEIGHT_W'($urandom_range(511)) - 32'sd256;
        return r;
    endfunction

    // A read request, half the time of the entry filled last. The event
    // fields stay random since the block must ignore them.
    function automatic pair_req_t read_pair();
        pair_req_t r;
        r        = noise_pair();
        r.action = 1'b1;
        if ($urandom_range(1) == 0)
            r.read_entry = last_filled;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Sends one request and records its expected result. Valid is left high
    // on return; the next request, a gap or a drain takes it from there, so
    // valid never goes low and high again within one edge.
    task automatic send_request(pair_req_t r);
        bit        taken;
        pair_res_t predicted;
        if (idle_enable && $urandom_range(99) < 20) begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        evt.valid         <= 1'b1;
        evt.action        <= r.action;
        evt.eta_a         <= r.eta_a;
        evt.eta_b         <= r.eta_b;
        evt.pt_a          <= r.pt_a;
        evt.pt_b          <= r.pt_b;
        evt.mass          <= r.mass;
        evt.same_sign     <= r.same_sign;
        evt.opposite_sign <= r.opposite_sign;
        evt.tight_a       <= r.tight_a;
        evt.tight_b       <= r.tight_b;
        evt.weight        <= r.weight;
        evt.read_entry    <= r.read_entry;
        // Ready is sampled on the falling edge, where nothing is moving; the
        // request is taken at the rising edge that follows.
        do begin
            @(negedge clk);
            taken = evt.ready;
            if (taken) begin
                predicted       = accumulate_pair(r);
                pending_results = {pending_results, predicted};
            end
            @(posedge clk);
        end while (!taken);
    endtask

    // Holds off new requests until every owed result has come back, then
    // lets the block settle.
    task automatic drain_results();
        evt.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, bit [63:0] data);
        bit taken;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do begin
            @(negedge clk);
            taken = cfg.ready;
            @(posedge clk);
        end while (!taken);
        case (idx)
            CFG_ETA_EDGES:    eta_edges_q = data;
            CFG_PT_EDGES:     pt_edges_q  = data;
            CFG_MASS_LOW:     mass_low_q  = data[MASS_W-1:0];
            CFG_MASS_HIGH:    mass_high_q = data[MASS_W-1:0];
            CFG_PEAK_LOW:     peak_low_q  = data[MASS_W-1:0];
            CFG_PEAK_HIGH:    peak_high_q = data[MASS_W-1:0];
            CFG_SUBTRACT_BKG: subtract_q  = data[0];
            CFG_IS_DATA:      is_data_q   = data[0];
            default:          ;
        endcase
    endtask

    // Writes all eight registers once the block has gone quiet.
    task automatic write_settings(bit [63:0] eta, bit [63:0] pt, bit [15:0] m_lo,
                                  bit [15:0] m_hi, bit [15:0] p_lo, bit [15:0] p_hi,
                                  bit sub, bit dat);
        drain_results();
        cfg_write(CFG_ETA_EDGES, eta);
        cfg_write(CFG_PT_EDGES, pt);
        cfg_write(CFG_MASS_LOW, 64'(m_lo));
        cfg_write(CFG_MASS_HIGH, 64'(m_hi));
        cfg_write(CFG_PEAK_LOW, 64'(p_lo));
        cfg_write(CFG_PEAK_HIGH, 64'(p_hi));
        cfg_write(CFG_SUBTRACT_BKG, 64'(sub));
        cfg_write(CFG_IS_DATA, 64'(dat));
        cfg.valid <= 1'b0;
    endtask

    // Mostly well-formed pairs, some reads and some noise. Once in a while
    // the sender waits for the block to empty completely.
    task automatic run_random_items(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if ($urandom_range(199) == 0)
                drain_results();
            if (kind < 15)
                send_request(read_pair());
            else if (kind < 80)
                send_request(well_formed_pair());
            else
                send_request(noise_pair());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: every rejection reason, the window bounds, the sign
    // flags, unbinned and overflowing leptons, weight extremes, pair
    // ordering and reads of untouched entries in both tables.
    task automatic test_reset_settings();
        pair_req_t r;
        int        b, lo_v, hi_v;
        r = read_pair();
        r.read_entry = '0;
        send_request(r);
        r.read_entry = '1;
        send_request(r);

        r = well_formed_pair();
        r.tight_a = 1'b0;
        send_request(r);
        r = well_formed_pair();
        r.tight_b = 1'b0;
        send_request(r);
        r = noise_pair();
        {r.tight_a, r.tight_b} = 2'b00;
        r.eta_a = '1;
        r.pt_a  = '1;
        r.mass  = '1;
        send_request(r);

        r = well_formed_pair();
        r.mass = mass_low_q - 1'b1;
        send_request(r);
        r.mass = mass_high_q + 1'b1;
        send_request(r);
        r.mass = '0;
        send_request(r);
        r.mass = '1;
        send_request(r);
        r.mass = mass_low_q;
        send_request(r);
        r.mass = mass_high_q;
        send_request(r);

        // Neither sign flag, then both (same sign wins), then opposite only.
        {r.same_sign, r.opposite_sign} = 2'b00;
        send_request(r);
        {r.same_sign, r.opposite_sign} = 2'b11;
        send_request(r);
        {r.same_sign, r.opposite_sign} = 2'b01;
        send_request(r);

        r.eta_a = '0;
        r.eta_b = '1;
        send_request(r);
        r = well_formed_pair();
        r.pt_a = '0;
        send_request(r);

        // Pt beyond every edge, with the largest and smallest weights.
        r.pt_a   = '1;
        r.pt_b   = '1;
        r.weight = 32'sh7FFF_FFFF;
        send_request(r);
        r.weight = 32'sh8000_0000;
        send_request(r);

        // First lepton in a higher eta bin than the second, so the block
        // has to swap them.
        lo_v = -1;
        hi_v = -1;
        for (int v = 0; v < 2**ETA_W; v++) begin
            b = eta_bin_of(v);
            if (b >= 0 && (lo_v < 0 || b < eta_bin_of(lo_v)))
                lo_v = v;
            if (b >= 0 && (hi_v < 0 || b > eta_bin_of(hi_v)))
                hi_v = v;
        end
        if (lo_v >= 0) begin
            r = well_formed_pair();
            r.eta_a = ETA_W'(hi_v);
            r.eta_b = ETA_W'(lo_v);
            send_request(r);
        end
        r = read_pair();
        r.read_entry = last_filled;
        send_request(r);

        run_random_items(150);
    endtask

    // Ascending edges, open window, subtraction on: odd weights off the peak
    // exercise the rounding of the half weight, and both peak bounds are
    // checked to be exclusive. The random part then runs with no idling.
    task automatic test_half_weight();
        pair_req_t r;
        write_settings(64'({10'd0, 9'd300, 9'd200, 9'd120, 9'd60, 9'd0}),
                       64'({12'd160, 12'd80, 12'd40, 12'd20, 12'd0}),
                       16'h0000, 16'hFFFF, 16'd1296, 16'd1616, 1'b1, 1'b0);
        r = well_formed_pair();
        {r.same_sign, r.opposite_sign} = 2'b10;
        r.mass   = peak_low_q;
        r.weight = -32'sd3;
        send_request(r);
        r.weight = 32'sd3;
        send_request(r);
        r.mass   = peak_high_q;
        r.weight = 32'sh8000_0000;
        send_request(r);
        r.weight = 32'sh7FFF_FFFF;
        send_request(r);
        r.mass   = peak_low_q + 1'b1;
        r.weight = -32'sd3;
        send_request(r);
        r.mass   = peak_high_q - 1'b1;
        send_request(r);
        r = read_pair();
        r.read_entry = last_filled;
        send_request(r);

        idle_enable = 1'b0;
        run_random_items(200);
        idle_enable = 1'b1;
    endtask

    // Drives one same-sign entry into the positive clamp and one
    // opposite-sign entry into the negative clamp, then steps it back out.
    // Mass sits on the peak so the weights are taken unscaled.
    task automatic test_saturation();
        pair_req_t r;
        pair_req_t rd;
        r = well_formed_pair();
        r.mass = peak_low_q + 1'b1;
        {r.same_sign, r.opposite_sign} = 2'b10;
        r.weight = 32'sh7FFF_FFFF;
        repeat (260) send_request(r);
        rd = read_pair();
        rd.read_entry = last_filled;
        send_request(rd);

        {r.same_sign, r.opposite_sign} = 2'b01;
        r.weight = 32'sh8000_0000;
        repeat (260) send_request(r);
        rd.read_entry = last_filled;
        send_request(rd);
        r.weight = 32'sd1;
        send_request(r);
        send_request(rd);
    endtask

    // Edge registers all zero, then all one; mass window open, then inverted.
    task automatic test_config_extremes();
        write_settings(64'd0, 64'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
        run_random_items(60);
        write_settings(64'h007F_FFFF_FFFF_FFFF, 64'h0FFF_FFFF_FFFF_FFFF,
                       16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        run_random_items(40);
    endtask

    // Random settings, mostly ascending edges so that events land in bins.
    task automatic test_random_settings();
        bit [63:0] eta, pt;
        int        acc;
        bit [15:0] m_lo, m_hi, p_lo;
        for (int n = 0; n < 4; n++) begin
            eta = '0;
            acc = $urandom_range(80);
            for (int k = 0; k < ETA_EDGE_COUNT; k++) begin
                eta[ETA_W*k +: ETA_W] = ETA_W'(acc > 511 ? 511 : acc);
                acc += $urandom_range(1, 110);
            end
            eta[54:45] = 10'($urandom);
            if ($urandom_range(3) == 0)
                eta = {$urandom, $urandom} & 64'h007F_FFFF_FFFF_FFFF;

            pt  = '0;
            acc = $urandom_range(200);
            for (int k = 0; k < PT_EDGE_COUNT; k++) begin
                pt[PT_W*k +: PT_W] = PT_W'(acc > 4095 ? 4095 : acc);
                acc += $urandom_range(1, 600);
            end
            if ($urandom_range(3) == 0)
                pt = {$urandom, $urandom} & 64'h0FFF_FFFF_FFFF_FFFF;

            m_lo = 16'($urandom_range(3000));
            m_hi = m_lo + 16'($urandom_range(30000));
            p_lo = 16'($urandom_range(m_hi, m_lo));
            write_settings(eta, pt, m_lo, m_hi, p_lo, p_lo + 16'($urandom_range(2000)),
                           1'($urandom), 1'($urandom));
            run_random_items(60);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the result checker
    // ------------------------------------------------------------------

    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= idle_enable ? ($urandom_range(99) >= 20) : 1'b1;
        end
    end

    // Everything is sampled on the falling edge: inputs only move on the
    // rising edge, so what is seen here is what the next rising edge takes.
    // The same sample feeds the watchdog, which counts cycles in which no
    // request, result or register write moves.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (res.valid && res.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    64'(res.entry_index), 64'd0);
                end
                else begin
                    oldest_result = pending_results.pop_front();
                    if (res.status !== oldest_result.status)
                        report_mismatch("status", 64'(res.status), 64'(oldest_result.status));
                    if (res.entry_index !== oldest_result.entry_index)
                        report_mismatch("entry_index", 64'(res.entry_index),
                                        64'(oldest_result.entry_index));
                    if (res.value !== oldest_result.value)
                        report_mismatch("value", 64'(res.value), 64'(oldest_result.value));
                end
            end
            if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("lepton_pair_binned_accumulator_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n             <= 1'b0;
        evt.valid         <= 1'b0;
        evt.action        <= 1'b0;
        evt.eta_a         <= '0;
        evt.eta_b         <= '0;
        evt.pt_a          <= '0;
        evt.pt_b          <= '0;
        evt.mass          <= '0;
        evt.same_sign     <= 1'b0;
        evt.opposite_sign <= 1'b0;
        evt.tight_a       <= 1'b0;
        evt.tight_b       <= 1'b0;
        evt.weight        <= '0;
        evt.read_entry    <= '0;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_ETA_EDGES;
        cfg.data          <= '0;

        // The predictor starts from the same state the block resets to.
        eta_edges_q    = 64'(ETA_EDGES_RESET);
        pt_edges_q     = 64'(PT_EDGES_RESET);
        mass_low_q     = MASS_LOW_RESET;
        mass_high_q    = MASS_HIGH_RESET;
        peak_low_q     = PEAK_LOW_RESET;
        peak_high_q    = PEAK_HIGH_RESET;
        subtract_q     = 1'b0;
        is_data_q      = 1'b0;
        last_filled    = '0;
        idle_enable    = 1'b1;
        error_count    = 0;
        stalled_cycles = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            same_sign_sums[i]     = 0;
            opposite_sign_sums[i] = 0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_half_weight();
        test_saturation();
        test_config_extremes();
        test_random_settings();

        // Everything owed must have arrived; waiting on afterwards catches any
        // stray result the block might still put out.
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("lepton_pair_binned_accumulator_tb passed");
        else
            $display("lepton_pair_binned_accumulator_tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lpba_pkg.sv
rtl/core/lpba_evt_if.sv
rtl/core/lpba_res_if.sv
rtl/core/lpba_cfg_if.sv
rtl/core/lpba_front.sv
rtl/core/lpba_queue.sv
rtl/core/lpba_back.sv
rtl/core/lepton_pair_binned_accumulator.sv
bench/lepton_pair_binned_accumulator_tb.sv
